### hw/rtl/sieve_trigger_generator_top_macros.svh
// Assertion macros for the sieve trigger generator
`ifndef SIEVE_TRIGGER_GENERATOR_TOP_MACROS_SVH
`define SIEVE_TRIGGER_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define STG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stg assertion failed");
// next-cycle implication, checked out of reset
`define STG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stg assertion failed");
`else
`define STG_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define STG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/stg_pkg.sv
// Shared types, constants and helpers of the sieve trigger generator
`default_nettype none
package stg_pkg;

    localparam int MAX_PERIOD  = 64;
    localparam int PERIOD_W    = $clog2(MAX_PERIOD) + 1;
    localparam int RES_W       = 6;
    localparam int PHASE_W     = 48;
    localparam int FRAC_W      = 16;
    localparam int INT_W       = 32;
    localparam int DIFF_W      = INT_W + 1;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PERIOD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SHIFT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MASK   = 2'd2;

    typedef struct packed {
        logic signed [31:0] rate_step;
        logic [16:0]        gate_width;
    } stg_in_t;

    typedef struct packed {
        logic             trigger;
        logic [RES_W-1:0] residue;
    } stg_out_t;

    // request to the residue unit
    typedef struct packed {
        logic                     start;
        logic                     take;
        logic signed [DIFF_W-1:0] diff;
        logic [PERIOD_W-1:0]      period;
    } stg_req_t;

    // status from the residue unit
    typedef struct packed {
        logic             valid;
        logic [RES_W-1:0] residue;
    } stg_rsp_t;

    // zero period acts as 1, large periods saturate
    function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
        logic [PERIOD_W-1:0] r;
        r = p;
        if (p == '0)
        begin
            r = PERIOD_W'(1);
        end
        else if (p > PERIOD_W'(MAX_PERIOD))
        begin
            r = PERIOD_W'(MAX_PERIOD);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/stg_residue_unit.sv
// Bit-serial floored modulo of a signed difference by the period
`default_nettype none
module stg_residue_unit import stg_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  stg_req_t req,
    output stg_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIFF_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABS,
        ST_DIV,
        ST_FIX,
        ST_HOLD
    } state_t;

    state_t                   state_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [DIFF_W-1:0]        mag_reg;
    logic                     neg_reg;
    logic [PERIOD_W-1:0]      period_reg;
    logic [RES_W-1:0]         rem_reg;
    logic [CNT_W-1:0]         cnt_reg;

    logic [PERIOD_W-1:0] trial;
    logic                fits;
    logic [PERIOD_W-1:0] trial_sub;
    logic [PERIOD_W-1:0] fix_sub;

    // one restoring step: bring in the next magnitude bit
    assign trial     = {rem_reg, mag_reg[DIFF_W-1]};
    assign fits      = (trial >= period_reg);
    assign trial_sub = trial - period_reg;
    // negative dividend with nonzero remainder wraps to period - rem
    assign fix_sub   = period_reg - {1'b0, rem_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.start)
                    begin
                        diff_reg   <= req.diff;
                        period_reg <= req.period;
                        state_reg  <= ST_ABS;
                    end
                end
                ST_ABS:
                begin
                    neg_reg   <= diff_reg[DIFF_W-1];
                    mag_reg   <= diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg <= fits ? trial_sub[RES_W-1:0] : trial[RES_W-1:0];
                    mag_reg <= {mag_reg[DIFF_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIFF_W - 1))
                    begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX:
                begin
                    if (neg_reg && (rem_reg != '0))
                    begin
                        rem_reg <= fix_sub[RES_W-1:0];
                    end
                    state_reg <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (req.take)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid   = (state_reg == ST_HOLD);
    assign rsp.residue = rem_reg;

endmodule
`default_nettype wire

### hw/rtl/sieve_trigger_generator_top.sv
// Sieve trigger generator: phase accumulator, residue test and output register
// Each accepted sample is reduced to a residue by a bit-serial remainder unit that
// handles one bit of the 33-bit shifted integer phase per cycle; in_stall stays high
// from acceptance until the sample's result reaches the output register. The finished
// request is held in the output register while the next sample is accepted.
// Configuration writes are always ready and take effect at once; write them only
// while no sample is open.
`default_nettype none
`include "sieve_trigger_generator_top_macros.svh"
module sieve_trigger_generator_top import stg_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  stg_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output stg_out_t               out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [PERIOD_W-1:0]      period_reg;
    logic signed [INT_W-1:0]  shift_reg;
    logic [CFG_DATA_W-1:0]    mask_reg;
    logic [PHASE_W-1:0]       phase_reg;
    logic [PHASE_W-1:0]       phase_next;
    logic                     busy_reg;
    logic                     busy_next;
    logic                     gate_ok_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    stg_out_t                 out_data_reg;

    logic                     in_accept;
    logic                     take;
    logic                     gate_ok;
    logic signed [DIFF_W-1:0] diff;
    logic [PERIOD_W-1:0]      period_eff;
    stg_req_t                 req;
    stg_rsp_t                 rsp;

    assign in_stall   = busy_reg;
    assign in_accept  = in_valid && !busy_reg;
    assign cfg_ready  = 1'b1;
    assign period_eff = eff_period(period_reg);

    // shifted integer phase and fraction test of the current phase
    assign diff    = DIFF_W'($signed(phase_reg[PHASE_W-1:FRAC_W]))
                   - DIFF_W'(shift_reg);
    assign gate_ok = ({1'b0, phase_reg[FRAC_W-1:0]} <= in_data.gate_width);

    // phase advance with sign-extended step, wraps at 48 bits
    assign phase_next = in_accept
                      ? phase_reg + PHASE_W'($signed(in_data.rate_step))
                      : phase_reg;

    // residue moves to the output register once the slot is free
    assign take           = rsp.valid && (!out_valid_reg || !out_stall);
    assign out_valid_next = take ? 1'b1 : (out_valid_reg && out_stall);
    assign busy_next      = in_accept ? 1'b1 : (take ? 1'b0 : busy_reg);

    assign req.start  = in_accept;
    assign req.take   = take;
    assign req.diff   = diff;
    assign req.period = period_eff;

    stg_residue_unit u_residue (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_W'(1);
            shift_reg  <= '0;
            mask_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IDX_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_IDX_SHIFT:  shift_reg  <= cfg_data[INT_W-1:0];
                CFG_IDX_MASK:   mask_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // phase and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            gate_ok_reg <= gate_ok;
        end
        if (take)
        begin
            out_data_reg.trigger <= gate_ok_reg && mask_reg[rsp.residue];
            out_data_reg.residue <= rsp.residue;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // an accepted sample keeps the input stalled on the next cycle
    `STG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall)
    // a finished residue only exists while a sample is open
    `STG_ASSERT_IMPLY(a_rsp_while_busy, clk, rst_n, rsp.valid, busy_reg)
    // delivered residue is below the effective period
    `STG_ASSERT_IMPLY(a_residue_range, clk, rst_n, out_valid_reg,
        {1'b0, out_data_reg.residue} < period_eff)

endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking testbench for the sieve trigger generator top level
`timescale 1ns / 100ps

module testbench;
    import stg_pkg::*;

    // index with no register behind it, writes must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int CLK_PERIOD = 12;
    localparam int RUN_LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 48;
    localparam int MAX_REPORTS = 10;

    // Tracks phase and register copies, predicts trigger/residue per sample
    class sieve_scoreboard;
        logic [6:0]         period_reg;
        logic signed [31:0] shift_reg;
        logic [63:0]        mask_reg;
        logic [47:0]        phase_acc;
        stg_out_t           expected_q[$];
        int                 errors;

        function void clear_state();
            period_reg = 7'd1;
            shift_reg  = '0;
            mask_reg   = '0;
            phase_acc  = '0;
            expected_q.delete();
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] data);
            if (idx == CFG_IDX_PERIOD)
            begin
                period_reg = data[6:0];
            end
            else if (idx == CFG_IDX_SHIFT)
            begin
                shift_reg = data[31:0];
            end
            else if (idx == CFG_IDX_MASK)
            begin
                mask_reg = data;
            end
        endfunction

        // residue of (floor(phase) - shift) mod period, then advance the phase
        function void note_sample(stg_in_t s);
            longint   int_part;
            longint   diff;
            longint   modulus;
            longint   rem;
            stg_out_t exp_out;
            int_part = longint'($signed(phase_acc[47:16]));
            diff     = int_part - longint'(shift_reg);
            modulus  = longint'(period_reg);
            if (modulus == 0)
            begin
                modulus = 1;
            end
            else if (modulus > MAX_PERIOD)
            begin
                modulus = MAX_PERIOD;
            end
            rem = diff % modulus;
            if (rem < 0)
            begin
                rem = rem + modulus;
            end
            exp_out.residue = rem[5:0];
            exp_out.trigger = mask_reg[rem[5:0]] && ({1'b0, phase_acc[15:0]} <= s.gate_width);
            expected_q.push_back(exp_out);
            phase_acc = phase_acc + {{16{s.rate_step[31]}}, s.rate_step};
        endfunction

        function void check_result(stg_out_t got);
            stg_out_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("unexpected result: trigger=%0d residue=%0d",
                             got.trigger, got.residue);
                end
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.trigger !== want.trigger || got.residue !== want.residue)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected trigger=%0d residue=%0d, got trigger=%0d residue=%0d",
                                 want.trigger, want.residue, got.trigger, got.residue);
                    end
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    stg_in_t                in_data;
    logic                   out_valid;
    logic                   out_stall;
    stg_out_t               out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sieve_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;

    sieve_trigger_generator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // hard stop in case the block hangs
    initial
    begin
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("testbench failed");
        $finish;
    end

    // result side: check at the rising edge, pick the stall at the falling edge
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sb.check_result(out_data);
            end
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall = 1'b1;
            end
            else
            begin
                out_stall = ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // one register write; caller drops cfg_valid after the last one
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic configure(input logic [63:0] period, input logic [63:0] shift,
                             input logic [63:0] mask);
        write_reg(CFG_IDX_PERIOD, period);
        write_reg(CFG_IDX_SHIFT, shift);
        write_reg(CFG_IDX_MASK, mask);
        cfg_valid = 1'b0;
    endtask

    // offer one sample, with a random gap first, and wait for it to be taken
    task automatic send_sample(input stg_in_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = s;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_sample(s);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic [31:0] step, input logic [16:0] width);
        stg_in_t s;
        s.rate_step  = step;
        s.gate_width = width;
        send_sample(s);
    endtask

    // wait for every outstanding result
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (2) @(negedge clk);
    endtask

    function automatic stg_in_t pick_sample();
        stg_in_t s;
        int      sel;
        sel = $urandom_range(99);
        if (sel < 45)
        begin
            s.rate_step = $urandom_range(0, 32'h0004_0000);
        end
        else if (sel < 60)
        begin
            s.rate_step = 32'd0 - $urandom_range(1, 32'h0004_0000);
        end
        else if (sel < 80)
        begin
            s.rate_step = $urandom;
        end
        else if (sel < 92)
        begin
            // near whole steps, lands on fractions close to zero
            s.rate_step = ($urandom_range(0, 8) << 16) + $urandom_range(0, 2) - 1;
        end
        else
        begin
            s.rate_step = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        end
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            s.gate_width = 17'($urandom_range(0, 16'hFFFF));
        end
        else if (sel < 55)
        begin
            s.gate_width = 17'h1_0000;
        end
        else if (sel < 70)
        begin
            s.gate_width = 17'($urandom_range(0, 17'h1_FFFF));
        end
        else if (sel < 82)
        begin
            s.gate_width = '0;
        end
        else
        begin
            s.gate_width = 17'($urandom_range(0, 16'h1FFF));
        end
        return s;
    endfunction

    // period value with random junk above the 7 register bits
    function automatic logic [63:0] pick_period();
        logic [63:0] junk;
        logic [6:0]  p;
        junk = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: p = 7'd0;
            1: p = 7'd1;
            2: p = 7'd64;
            3: p = 7'($urandom_range(65, 127));
            4: p = 7'd127;
            default: p = 7'($urandom_range(1, 64));
        endcase
        return {junk[63:7], p};
    endfunction

    function automatic logic [63:0] pick_shift();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'd0 - $urandom_range(0, 200);
            3: v = $urandom_range(0, 200);
            default: v = $urandom;
        endcase
        return {$urandom, v};
    endfunction

    function automatic logic [63:0] pick_mask();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = 64'd1 << $urandom_range(0, 63);
            3: v = {$urandom, $urandom} & {$urandom, $urandom};
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // main sequence
    initial
    begin
        sb = new;
        sb.clear_state();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_IDX_PERIOD;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // reset values: period 1, empty mask
        send_fields(32'h0001_8000, 17'h0_8000);
        send_fields(32'h0000_0000, 17'h1_0000);
        drain();

        // small period, negative shift, field extremes, wrap through zero
        configure(64'd7, 64'hFFFF_FFFF_FFFF_FFFD, 64'h5555_5555_5555_5555);
        send_fields(32'h0000_0000, 17'h0_0000);
        send_fields(32'h0001_0000, 17'h0_FFFF);
        send_fields(32'hFFFF_FFFF, 17'h1_0000);
        send_fields(32'h7FFF_FFFF, 17'h1_FFFF);
        send_fields(32'h8000_0000, 17'h0_0000);
        send_fields(32'h8000_0000, 17'h0_FFFF);
        send_fields(32'hFFFE_8000, 17'h0_7FFF);
        send_fields(32'h0003_0001, 17'h0_8000);
        drain();

        // zero period behaves as one
        configure(64'd0, 64'd5, 64'h1);
        send_fields(32'h0002_4000, 17'h1_0000);
        send_fields(32'hFFF0_0000, 17'h0_0000);
        send_fields(32'h0000_0001, 17'h0_4000);
        drain();

        // oversized period saturates; dropped write to the spare index
        configure(64'hFFFF_FFFF_FFFF_FF7F, 64'h0000_0000_7FFF_FFFF, '1);
        write_reg(CFG_IDX_SPARE, 64'h0123_4567_89AB_CDEF);
        cfg_valid = 1'b0;
        send_fields(32'h0005_0000, 17'h1_0000);
        send_fields(32'h0000_C000, 17'h0_0000);
        send_fields(32'hFFFF_0000, 17'h0_C000);
        drain();
        configure(64'd64, 64'h8000_0000, 64'h8000_0000_0000_0001);
        send_fields(32'h0001_0000, 17'h1_0000);
        send_fields(32'h003F_0000, 17'h1_0000);
        send_fields(32'h0000_0000, 17'h0_0000);
        drain();

        // random part: three idling profiles, six register settings each
        for (int stage = 0; stage < 3; stage++)
        begin
            case (stage)
                0:
                begin
                    send_idle_pct  = 16;
                    recv_stall_pct = 76;
                end
                1:
                begin
                    send_idle_pct  = 76;
                    recv_stall_pct = 16;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int setting = 0; setting < 6; setting++)
            begin
                configure(pick_period(), pick_shift(), pick_mask());
                if ($urandom_range(3) == 0)
                begin
                    write_reg(CFG_IDX_SPARE, {$urandom, $urandom});
                    cfg_valid = 1'b0;
                end
                // long receiver hold while samples keep coming
                if (stage == 2 && setting == 1)
                begin
                    hold_request = 400;
                end
                for (int n = 0; n < 100; n++)
                begin
                    send_sample(pick_sample());
                end
                drain();
            end
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
